// ===== hdl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry package
// Shared widths, constants, handshake structs and helper functions for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Serial multiplier: a (MUL_A_W) times b (MUL_B_W), one bit of b per cycle.
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 46;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial restoring divider.
  localparam int DIV_N_W = 84;
  localparam int DIV_D_W = 56;
  localparam int DIV_Q_W = 33;

  // Configuration register indexes.
  localparam logic CFG_METERS_PER_COUNT = 1'b0;
  localparam logic CFG_TRACK_WIDTH      = 1'b1;

  localparam logic [31:0] MPC_RESET = 32'd449769;
  localparam logic [23:0] TW_RESET  = 24'd14746;

  // round(2^48 / (2*pi)), converts radians * 2^16 into 2^-32 turn.
  localparam logic [MUL_B_W-1:0] TURN_SCALE = 46'd44798133900177;
  localparam logic [MUL_B_W-1:0] USEC       = 46'd1000000;
  // CORDIC start gain, 0.60725293 in Q30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
    logic               rnd;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
    logic               ovf;
  } div_rsp_t;

  // Arctangent table in units of 2^-32 turn.
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Signed 32-bit saturation of a magnitude quotient.
  function automatic logic [31:0] sat32(input logic [DIV_Q_W-1:0] q, input logic ovf,
                                        input logic neg);
    logic [31:0] v;
    if (neg) begin
      if (ovf || q[32] || (q[31] && (q[30:0] != '0))) v = 32'h80000000;
      else v = ~q[31:0] + 32'd1;
    end else begin
      if (ovf || q[32] || q[31]) v = 32'h7FFFFFFF;
      else v = q[31:0];
    end
    return v;
  endfunction

endpackage

// ===== hdl/ddo_in_if.sv =====
// ----------------------------------------------------------------------------
// Odometry input channel
// Valid/ready channel carrying one encoder sample.
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  logic [31:0]        stamp_us;

  modport source(output valid, output left_count, output right_count, output stamp_us,
                 input ready);
  modport sink(input valid, input left_count, input right_count, input stamp_us,
               output ready);
endinterface

// ===== hdl/ddo_out_if.sv =====
// ----------------------------------------------------------------------------
// Odometry result channel
// Valid/ready channel carrying one pose and velocity report.
// ----------------------------------------------------------------------------
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_pos;
  logic signed [47:0] y_pos;
  logic [31:0]        heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic               dt_zero;

  modport source(output valid, output x_pos, output y_pos, output heading, output vel_x,
                 output vel_y, output yaw_rate, output dt_zero, input ready);
  modport sink(input valid, input x_pos, input y_pos, input heading, input vel_x,
               input vel_y, input yaw_rate, input dt_zero, output ready);
endinterface

// ===== hdl/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Midpoint-rule wheel odometry with serial multiply, divide and CORDIC.
// ----------------------------------------------------------------------------
// One encoder sample is taken at a time; the next is accepted once the
// current pose is placed in the output register, even while that report still
// waits for a transfer. All wide arithmetic runs on one shift-and-add
// multiplier and one restoring divider, plus an iterative CORDIC rotation.
// When the time step is zero, the velocity products and quotients are
// skipped.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IT_W = $clog2(CORDIC_STEPS);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_PREP   = 19'h00002,
    S_MUL_P  = 19'h00004,
    S_MUL_PD = 19'h00008,
    S_MUL_DA = 19'h00010,
    S_DIV_DA = 19'h00020,
    S_CINIT  = 19'h00040,
    S_CORDIC = 19'h00080,
    S_MUL_DX = 19'h00100,
    S_MUL_DY = 19'h00200,
    S_POS    = 19'h00400,
    S_MUL_TD = 19'h00800,
    S_MUL_VX = 19'h01000,
    S_DIV_VX = 19'h02000,
    S_MUL_VY = 19'h04000,
    S_DIV_VY = 19'h08000,
    S_MUL_VW = 19'h10000,
    S_DIV_VW = 19'h20000,
    S_DONE   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;

  logic [31:0] m_r;
  logic [23:0] tw_r;
  logic [23:0] tw_eff;
  logic [47:0] pos_x_r, pos_y_r;
  logic [31:0] yaw_r;
  logic [31:0] last_l_r, last_rt_r, last_s_r;

  logic [31:0] dl_r, dr_r, dt_r;
  logic        sum_neg_r, dif_neg_r;
  logic [32:0] sum_mag_r, dif_mag_r;
  logic [55:0] ds_r;
  logic [63:0] pd_r;
  logic [32:0] da_r;
  logic        flip_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [IT_W-1:0]    it_r;
  logic [63:0] rdx_r, rdy_r;
  logic        sdx_r, sdy_r;
  logic [55:0] td_r;
  logic [31:0] vx_r, vy_r, vw_r;

  logic               out_valid_r;
  logic signed [47:0] ox_r, oy_r;
  logic [31:0]        oh_r;
  logic signed [31:0] ovx_r, ovy_r, ovw_r;
  logic               odz_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_acc, out_load, dtz, last_it, is_mul, is_div;
  logic [32:0] sum_s, dif_s;
  logic [33:0] ax, ay;
  logic [31:0] mid, rot;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  ddo_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  ddo_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign tw_eff   = (tw_r == '0) ? 24'd1 : tw_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign dtz      = (dt_r == '0);
  assign last_it  = (it_r == IT_W'(CORDIC_STEPS - 1));
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign sum_s = {dr_r[31], dr_r} + {dl_r[31], dl_r};
  assign dif_s = {dr_r[31], dr_r} - {dl_r[31], dl_r};
  assign ax    = x_r[33] ? -x_r : x_r;
  assign ay    = y_r[33] ? -y_r : y_r;
  assign mid   = yaw_r + da_r[32:1];
  // Angles in the left half-plane are turned by half a turn.
  assign rot   = {mid[30], mid[30:0]};
  assign xs    = x_r >>> it_r;
  assign ys    = y_r >>> it_r;
  assign at    = {1'b0, atan_tab(5'(it_r))};

  assign is_mul = (state_r == S_MUL_P) || (state_r == S_MUL_PD) || (state_r == S_MUL_DA) ||
                  (state_r == S_MUL_DX) || (state_r == S_MUL_DY) || (state_r == S_MUL_TD) ||
                  (state_r == S_MUL_VX) || (state_r == S_MUL_VY) || (state_r == S_MUL_VW);
  assign is_div = (state_r == S_DIV_DA) || (state_r == S_DIV_VX) ||
                  (state_r == S_DIV_VY) || (state_r == S_DIV_VW);

  always_comb begin
    mul_req.start = is_mul && !go_r;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state_r)
      S_MUL_P: begin
        mul_req.a = {32'b0, m_r};
        mul_req.b = {13'b0, sum_mag_r};
      end
      S_MUL_PD: begin
        mul_req.a = {32'b0, m_r};
        mul_req.b = {13'b0, dif_mag_r};
      end
      S_MUL_DA: begin
        mul_req.a = pd_r;
        mul_req.b = TURN_SCALE;
      end
      S_MUL_DX: begin
        mul_req.a = {8'b0, ds_r};
        mul_req.b = {14'b0, ax[31:0]};
      end
      S_MUL_DY: begin
        mul_req.a = {8'b0, ds_r};
        mul_req.b = {14'b0, ay[31:0]};
      end
      S_MUL_TD: begin
        mul_req.a = {32'b0, dt_r};
        mul_req.b = {22'b0, tw_eff};
      end
      S_MUL_VX: begin
        mul_req.a = rdx_r;
        mul_req.b = USEC;
      end
      S_MUL_VY: begin
        mul_req.a = rdy_r;
        mul_req.b = USEC;
      end
      S_MUL_VW: begin
        mul_req.a = pd_r;
        mul_req.b = USEC;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // The divider reads its dividend straight from the multiplier, which holds
  // the preceding product until its next start.
  always_comb begin
    div_req.start = is_div && !go_r;
    div_req.num   = '0;
    div_req.den   = '0;
    div_req.rnd   = 1'b0;
    unique case (state_r)
      S_DIV_DA: begin
        div_req.num = {6'b0, mul_rsp.prod[109:32]};
        div_req.den = {32'b0, tw_eff};
        div_req.rnd = mul_rsp.prod[31];
      end
      S_DIV_VX, S_DIV_VY: begin
        div_req.num = {8'b0, mul_rsp.prod[83:8]};
        div_req.den = {24'b0, dt_r};
        div_req.rnd = mul_rsp.prod[7];
      end
      S_DIV_VW: begin
        div_req.num = mul_rsp.prod[83:0];
        div_req.den = td_r;
        div_req.rnd = 1'b0;
      end
      default: begin
        div_req.num = '0;
        div_req.den = '0;
        div_req.rnd = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    if (mul_req.start || div_req.start) go_nxt = 1'b1;
    if ((is_mul && mul_rsp.done) || (is_div && div_rsp.done)) go_nxt = 1'b0;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_MUL_P;
      S_MUL_P:  if (mul_rsp.done) state_nxt = S_MUL_PD;
      S_MUL_PD: if (mul_rsp.done) state_nxt = S_MUL_DA;
      S_MUL_DA: if (mul_rsp.done) state_nxt = S_DIV_DA;
      S_DIV_DA: if (div_rsp.done) state_nxt = S_CINIT;
      S_CINIT:  state_nxt = S_CORDIC;
      S_CORDIC: if (last_it) state_nxt = S_MUL_DX;
      S_MUL_DX: if (mul_rsp.done) state_nxt = S_MUL_DY;
      S_MUL_DY: if (mul_rsp.done) state_nxt = S_POS;
      S_POS:    state_nxt = dtz ? S_DONE : S_MUL_TD;
      S_MUL_TD: if (mul_rsp.done) state_nxt = S_MUL_VX;
      S_MUL_VX: if (mul_rsp.done) state_nxt = S_DIV_VX;
      S_DIV_VX: if (div_rsp.done) state_nxt = S_MUL_VY;
      S_MUL_VY: if (mul_rsp.done) state_nxt = S_DIV_VY;
      S_DIV_VY: if (div_rsp.done) state_nxt = S_MUL_VW;
      S_MUL_VW: if (mul_rsp.done) state_nxt = S_DIV_VW;
      S_DIV_VW: if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      m_r         <= MPC_RESET;
      tw_r        <= TW_RESET;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      yaw_r       <= '0;
      last_l_r    <= '0;
      last_rt_r   <= '0;
      last_s_r    <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_METERS_PER_COUNT: m_r  <= cfg_wdata;
          CFG_TRACK_WIDTH:      tw_r <= cfg_wdata[23:0];
          default:              m_r  <= m_r;
        endcase
      end
      if (in_acc) begin
        last_l_r  <= in_ch.left_count;
        last_rt_r <= in_ch.right_count;
        last_s_r  <= in_ch.stamp_us;
      end
      if (state_r == S_CINIT) yaw_r <= yaw_r + da_r[31:0];
      if (state_r == S_POS) begin
        pos_x_r <= sdx_r ? pos_x_r - rdx_r[47:0] : pos_x_r + rdx_r[47:0];
        pos_y_r <= sdy_r ? pos_y_r - rdy_r[47:0] : pos_y_r + rdy_r[47:0];
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl_r <= in_ch.left_count - last_l_r;
      dr_r <= in_ch.right_count - last_rt_r;
      dt_r <= in_ch.stamp_us - last_s_r;
    end
    if (state_r == S_PREP) begin
      sum_neg_r <= sum_s[32];
      dif_neg_r <= dif_s[32];
      sum_mag_r <= sum_s[32] ? -sum_s : sum_s;
      dif_mag_r <= dif_s[32] ? -dif_s : dif_s;
    end
    if (mul_rsp.done) begin
      if (state_r == S_MUL_P)
        ds_r <= {1'b0, mul_rsp.prod[63:9]} + {55'b0, mul_rsp.prod[8]};
      if (state_r == S_MUL_PD) pd_r <= mul_rsp.prod[63:0];
      if (state_r == S_MUL_DX) begin
        rdx_r <= mul_rsp.prod[93:30] + {63'b0, mul_rsp.prod[29]};
        sdx_r <= sum_neg_r ^ x_r[33] ^ flip_r;
      end
      if (state_r == S_MUL_DY) begin
        rdy_r <= mul_rsp.prod[93:30] + {63'b0, mul_rsp.prod[29]};
        sdy_r <= sum_neg_r ^ y_r[33] ^ flip_r;
      end
      if (state_r == S_MUL_TD) td_r <= mul_rsp.prod[55:0];
    end
    if (div_rsp.done) begin
      if (state_r == S_DIV_DA) da_r <= dif_neg_r ? -div_rsp.quo : div_rsp.quo;
      if (state_r == S_DIV_VX) vx_r <= sat32(div_rsp.quo, div_rsp.ovf, sdx_r);
      if (state_r == S_DIV_VY) vy_r <= sat32(div_rsp.quo, div_rsp.ovf, sdy_r);
      if (state_r == S_DIV_VW) vw_r <= sat32(div_rsp.quo, div_rsp.ovf, dif_neg_r);
    end
    if (state_r == S_CINIT) begin
      flip_r <= mid[31] ^ mid[30];
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= {rot[31], rot};
      it_r   <= '0;
    end
    if (state_r == S_CORDIC) begin
      it_r <= it_r + 1'b1;
      if (!z_r[32]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (out_load) begin
      ox_r  <= pos_x_r;
      oy_r  <= pos_y_r;
      oh_r  <= yaw_r;
      ovx_r <= dtz ? 32'sd0 : vx_r;
      ovy_r <= dtz ? 32'sd0 : vy_r;
      ovw_r <= dtz ? 32'sd0 : vw_r;
      odz_r <= dtz;
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.x_pos    = ox_r;
  assign out_ch.y_pos    = oy_r;
  assign out_ch.heading  = oh_r;
  assign out_ch.vel_x    = ovx_r;
  assign out_ch.vel_y    = ovy_r;
  assign out_ch.yaw_rate = ovw_r;
  assign out_ch.dt_zero  = odz_r;

endmodule

// ===== hdl/ddo_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_P_W-1:0] p_r, p_nxt;
  logic [MUL_A_W:0]   sum;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    p_nxt    = p_r;
    sum      = {1'b0, p_r[MUL_P_W-1:MUL_B_W]} + (p_r[0] ? {1'b0, a_r} : '0);
    if (busy_r) begin
      // The upper half accumulates while the multiplier bits shift out below.
      p_nxt   = {sum, p_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cnt_nxt  = '0;
      end
    end else if (req.start) begin
      a_nxt    = req.a;
      p_nxt    = {{MUL_A_W{1'b0}}, req.b};
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = p_r;

endmodule

// ===== hdl/ddo_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, with a final round to
// nearest and an overflow flag for quotient bits above the kept width.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy_r, busy_nxt;
  logic               rph_r, rph_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_N_W-1:0] num_r, num_nxt;
  logic [DIV_D_W:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [DIV_Q_W-1:0] q_r, q_nxt;
  logic               ovf_r, ovf_nxt;
  logic               rin_r, rin_nxt;
  logic [DIV_D_W:0]   trial;
  logic               ge;
  logic               rup;
  logic [DIV_Q_W:0]   qinc;

  always_comb begin
    busy_nxt = busy_r;
    rph_nxt  = rph_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    rin_nxt  = rin_r;
    trial    = {rem_r[DIV_D_W-1:0], num_r[DIV_N_W-1]};
    ge       = trial >= {1'b0, den_r};
    // Round up when twice the remainder, plus the dropped fraction bit,
    // reaches the divisor.
    rup      = {rem_r, rin_r} >= {2'b00, den_r};
    qinc     = {1'b0, q_r} + {{DIV_Q_W{1'b0}}, rup};
    if (rph_r) begin
      q_nxt    = qinc[DIV_Q_W-1:0];
      ovf_nxt  = ovf_r | qinc[DIV_Q_W];
      rph_nxt  = 1'b0;
      done_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, den_r} : trial;
      num_nxt = {num_r[DIV_N_W-2:0], 1'b0};
      q_nxt   = {q_r[DIV_Q_W-2:0], ge};
      ovf_nxt = ovf_r | q_r[DIV_Q_W-1];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
        busy_nxt = 1'b0;
        rph_nxt  = 1'b1;
        cnt_nxt  = '0;
      end
    end else if (req.start) begin
      num_nxt  = req.num;
      den_nxt  = req.den;
      rin_nxt  = req.rnd;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rph_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rph_r  <= rph_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    rin_r <= rin_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.ovf  = ovf_r;

endmodule

// ===== bench/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// Odometry checker
// Watches the sample, report and configuration ports of the odometry block.
// It predicts each report from its own copy of the pose and settings, and
// compares the reports field by field in order.
// ----------------------------------------------------------------------------
module ddo_checker (
  input  logic        clk,
  input  logic        rst_n,
  ddo_in_if           in_ch,
  ddo_out_if          out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending,
  output int          checked
);
  import ddo_pkg::*;

  localparam int ROT_STEPS = 24;
  localparam longint START_GAIN = 652032874;
  localparam logic [63:0] RAD_TO_TURN = 64'd44798133900177;
  localparam logic [63:0] MICRO = 64'd1000000;

  localparam logic [31:0] ARCTAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [47:0] x_pos;
    logic [47:0] y_pos;
    logic [31:0] heading;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] yaw_rate;
    logic        dt_zero;
  } pose_report_t;

  pose_report_t pose_q[$];

  logic [31:0] mpc;
  logic [23:0] track;
  logic [47:0] pos_x, pos_y;
  logic [31:0] yaw, last_l, last_r, last_t;

  assign pending = pose_q.size();

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Quotient rounded half up on magnitudes.
  function automatic logic [127:0] div_near(input logic [127:0] n, input logic [63:0] d);
    return (n + 128'(d >> 1)) / 128'(d);
  endfunction

  function automatic logic [31:0] clamp_rate(input logic [127:0] q, input bit neg);
    if (neg) return (q > 128'h80000000) ? 32'h80000000 : -q[31:0];
    return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, xs, ys;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    a = flip ? ang + 32'h80000000 : ang;
    z = longint'(signed'(a));
    x = START_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ARCTAN[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ARCTAN[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint scale_q30(input longint d, input longint t);
    logic [127:0] w;
    logic [63:0] r;
    w = 128'(mag(d)) * 128'(mag(t)) + (128'd1 << 29);
    r = w[93:30];
    return ((d < 0) != (t < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [31:0] step_rate(input longint d, input logic [31:0] dt);
    return clamp_rate(div_near(128'(mag(d)) * 128'(MICRO), 64'(dt) << 8), d < 0);
  endfunction

  task automatic advance_pose(input logic [31:0] lc, input logic [31:0] rc,
                              input logic [31:0] st);
    logic signed [31:0] d32l, d32r;
    longint dl, dr, sum, dif, ds, c, s, dx, dy;
    logic [63:0] p, pd, dsm, da, half, tw;
    logic [127:0] q;
    logic [31:0] dt, mid;
    pose_report_t e;
    d32l = lc - last_l;
    d32r = rc - last_r;
    dl = d32l;
    dr = d32r;
    sum = dr + dl;
    dif = dr - dl;
    dt = st - last_t;
    tw = (track == 0) ? 64'd1 : 64'(track);

    p = mag(sum) * 64'(mpc);
    dsm = (p >> 9) + ((p >> 8) & 64'd1);
    ds = sum < 0 ? -longint'(dsm) : longint'(dsm);

    pd = mag(dif) * 64'(mpc);
    q = div_near(128'(pd) * 128'(RAD_TO_TURN), tw << 32);
    da = dif < 0 ? -q[63:0] : q[63:0];
    half = {da[63], da[63:1]};
    mid = yaw + half[31:0];

    rotate(mid, c, s);
    dx = scale_q30(ds, c);
    dy = scale_q30(ds, s);
    pos_x = pos_x + dx[47:0];
    pos_y = pos_y + dy[47:0];
    yaw = yaw + da[31:0];

    e.x_pos = pos_x;
    e.y_pos = pos_y;
    e.heading = yaw;
    if (dt == 0) begin
      e.vel_x = '0; e.vel_y = '0; e.yaw_rate = '0; e.dt_zero = 1'b1;
    end else begin
      e.vel_x = step_rate(dx, dt);
      e.vel_y = step_rate(dy, dt);
      e.yaw_rate = clamp_rate(div_near(128'(pd) * 128'(MICRO), tw * 64'(dt)), dif < 0);
      e.dt_zero = 1'b0;
    end
    pose_q.push_back(e);
    last_l = lc;
    last_r = rc;
    last_t = st;
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch on report %0d: %s got %h, expected %h", checked, what, got, want);
  endtask

  task automatic compare_report();
    pose_report_t e;
    if (pose_q.size() == 0) begin
      report("unexpected transfer", 64'd0, 64'd0);
      return;
    end
    e = pose_q.pop_front();
    if (out_ch.x_pos !== e.x_pos) report("x_pos", 64'(out_ch.x_pos), 64'(e.x_pos));
    if (out_ch.y_pos !== e.y_pos) report("y_pos", 64'(out_ch.y_pos), 64'(e.y_pos));
    if (out_ch.heading !== e.heading) report("heading", 64'(out_ch.heading), 64'(e.heading));
    if (out_ch.vel_x !== e.vel_x) report("vel_x", 64'(out_ch.vel_x), 64'(e.vel_x));
    if (out_ch.vel_y !== e.vel_y) report("vel_y", 64'(out_ch.vel_y), 64'(e.vel_y));
    if (out_ch.yaw_rate !== e.yaw_rate)
      report("yaw_rate", 64'(out_ch.yaw_rate), 64'(e.yaw_rate));
    if (out_ch.dt_zero !== e.dt_zero) report("dt_zero", 64'(out_ch.dt_zero), 64'(e.dt_zero));
    checked++;
  endtask

  initial begin
    errors = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mpc <= MPC_RESET;
      track <= TW_RESET;
      pos_x <= '0; pos_y <= '0; yaw <= '0;
      last_l <= '0; last_r <= '0; last_t <= '0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_METERS_PER_COUNT) mpc <= cfg_wdata;
        else track <= cfg_wdata[23:0];
      end
      if (out_ch.valid && out_ch.ready) compare_report();
      if (in_ch.valid && in_ch.ready) advance_pose(in_ch.left_count, in_ch.right_count,
                                                   in_ch.stamp_us);
    end
  end

endmodule

// ===== bench/diff_drive_odometry_tb.sv =====
// ----------------------------------------------------------------------------
// Odometry testbench
// Drives encoder samples with random gaps through several wheel settings,
// stalls the report side at random and once for a long stretch, and takes
// the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module diff_drive_odometry_tb;
  import ddo_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  int          errors, pending, checked;
  int          sent;
  int          hold_seq;
  bit          calm;
  logic [31:0] cur_l, cur_r, cur_t;

  ddo_in_if  in_ch();
  ddo_out_if out_ch();

  diff_drive_odometry i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  ddo_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Report side: random stalls, plus one long hold-off when asked.
  initial begin
    int stall, seen;
    stall = 0;
    seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        stall = 3000;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
                             input logic [31:0] t);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.left_count <= l;
    in_ch.right_count <= r;
    in_ch.stamp_us <= t;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    cur_l = l;
    cur_r = r;
    cur_t = t;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly smooth driving with small count steps; some spins, stopped clocks,
  // wild jumps and steps near the count wrap.
  task automatic random_sample();
    int r;
    logic [31:0] dl, dr, dt;
    r = $urandom_range(0, 99);
    dl = 32'($urandom_range(0, 4000)) - 32'd2000;
    dr = 32'($urandom_range(0, 4000)) - 32'd2000;
    dt = 32'($urandom_range(1000, 60000));
    if (r < 70) begin
    end else if (r < 78) begin
      dr = $urandom_range(0, 1) ? dl : -dl;
    end else if (r < 85) begin
      dt = '0;
    end else if (r < 93) begin
      dl = $urandom; dr = $urandom; dt = $urandom;
    end else begin
      dl = $urandom_range(0, 1) ? 32'h7FFFFFFF - dl[7:0] : 32'h80000000 + dl[7:0];
      dr = $urandom_range(0, 1) ? 32'h7FFFFFFF - dr[7:0] : 32'h80000000 + dr[7:0];
      dt = $urandom_range(0, 3);
    end
    send_sample(cur_l + dl, cur_r + dr, cur_t + dt);
  endtask

  initial begin
    logic [31:0] mpc_set [8];
    logic [23:0] tw_set [8];
    int n;
    rst_n = 1'b0;
    calm = 1'b0;
    hold_seq = 0;
    sent = 0;
    cur_l = '0; cur_r = '0; cur_t = '0;
    in_ch.valid <= 1'b0;
    in_ch.left_count <= '0;
    in_ch.right_count <= '0;
    in_ch.stamp_us <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_METERS_PER_COUNT;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at the reset settings.
    send_sample(32'd0, 32'd0, 32'd0);
    send_sample(32'd1000, 32'd1000, 32'd10000);
    send_sample(32'd1000, 32'd3000, 32'd20000);
    send_sample(32'd500, 32'd3000, 32'd20000);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd30000);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'd30001);
    send_sample(32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'd5);
    send_sample(32'hFFFFFFFF, 32'h00000000, 32'd6);
    send_sample(32'h00000000, 32'hFFFFFFFF, 32'h80000000);
    send_sample(32'h12345678, 32'hEDCBA987, 32'h80000000);
    send_sample(32'hAAAAAAAA, 32'h55555555, 32'h7FFFFFFF);
    send_sample(32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF + 32'd1);

    mpc_set = '{32'hFFFFFFFF, 32'd1, 32'd449769, 32'd0, 32'd0, 32'd0, 32'd1 << 20,
                MPC_RESET};
    tw_set = '{24'd1, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd65536, TW_RESET};
    for (int i = 3; i < 6; i++) begin
      mpc_set[i] = $urandom;
      tw_set[i] = 24'($urandom_range(1000, 200000));
    end

    for (int phase = 0; phase < 9; phase++) begin
      calm = (phase == 2);
      n = (phase == 0) ? 50 : 62;
      for (int k = 0; k < n; k++) begin
        if (phase == 4 && k == 10) hold_seq++;
        random_sample();
      end
      // The sender waits here until every report is back.
      drain();
      if (phase < 8) begin
        write_reg(CFG_METERS_PER_COUNT, mpc_set[phase]);
        write_reg(CFG_TRACK_WIDTH, 32'(tw_set[phase]));
      end
    end

    in_ch.valid <= 1'b0;
    repeat (1000) @(posedge clk);
    $display("Sent %0d encoder samples across 9 wheel settings; %0d reports compared.",
             sent, checked);
    $display("Covered count wrap, zero and wrapped time steps, zero track width, long stalls.");
    if (errors == 0 && pending == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
